// ===== rtl/serial_time_command_clock_assert.svh =====
// assertion macros shared by the serial time command clock rtl
`ifndef SERIAL_TIME_COMMAND_CLOCK_ASSERT_SVH
`define SERIAL_TIME_COMMAND_CLOCK_ASSERT_SVH

// same-cycle implication, checked out of reset
`define STCC_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define STCC_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/stcc_pkg.sv =====
package stcc_pkg;

    localparam int LINE_CAPACITY = 96;
    localparam int LEN_W         = $clog2(LINE_CAPACITY);
    localparam int CHAR_W        = 8;
    localparam int SECS_W        = 17;
    localparam int CNT_W         = 32;
    localparam int TPS_W         = 16;
    localparam int FLD_W         = 7;

    localparam logic [LEN_W-1:0]  LEN_LAST   = LEN_W'(LINE_CAPACITY - 1);
    localparam logic [SECS_W-1:0] SEC_LAST   = 17'd86399;
    localparam logic [SECS_W-1:0] SECS_HOUR  = 17'd3600;
    localparam logic [SECS_W-1:0] SECS_MIN   = 17'd60;
    localparam logic [FLD_W-1:0]  MAX_HOUR   = 7'd23;
    localparam logic [FLD_W-1:0]  MAX_MINSEC = 7'd59;
    localparam logic [TPS_W-1:0]  TPS_RESET  = 16'd1000;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CHAR_E     = 8'h45;
    localparam logic [CHAR_W-1:0] CHAR_I     = 8'h49;
    localparam logic [CHAR_W-1:0] CHAR_M     = 8'h4D;
    localparam logic [CHAR_W-1:0] CHAR_T     = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOW_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'h20;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_TIME_SET = 2'd1,
        EV_OTHER    = 2'd2,
        EV_OVERFLOW = 2'd3
    } stcc_event_t;

    typedef struct packed {
        logic start;
        logic ack;
    } stcc_chk_ctl_t;

    typedef struct packed {
        logic              done;
        logic              ok;
        logic [SECS_W-1:0] secs;
    } stcc_chk_res_t;

endpackage

// ===== rtl/stcc_ram.sv =====
module stcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 96
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/stcc_checker.sv =====
module stcc_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  stcc_pkg::stcc_chk_ctl_t             chk_ctl,
    input  logic [stcc_pkg::LEN_W-1:0]          line_len,
    input  logic [stcc_pkg::CHAR_W-1:0]         rd_data,
    output logic [stcc_pkg::LEN_W-1:0]          rd_addr,
    output stcc_pkg::stcc_chk_res_t             chk_res
);
    import stcc_pkg::*;

    typedef enum logic [3:0] {
        CS_IDLE  = 4'b0001,
        CS_PRE   = 4'b0010,
        CS_FIELD = 4'b0100,
        CS_DONE  = 4'b1000
    } chk_state_t;

    chk_state_t        state_reg, state_next;
    logic [3:0]        pos_reg, pos_next;
    logic [3:0]        fld_reg, fld_next;
    logic              ok_reg, ok_next;
    logic [3:0]        tens_reg, tens_next;
    logic [FLD_W-1:0]  hh_reg, hh_next;
    logic [FLD_W-1:0]  mm_reg, mm_next;
    logic [FLD_W-1:0]  ss_reg, ss_next;

    logic [CHAR_W-1:0] ch;
    logic [CHAR_W-1:0] ch_off;
    logic              is_dig;
    logic [3:0]        dig;
    logic [FLD_W-1:0]  pair_val;

    // character of the current position, zero past the line end
    assign ch       = (LEN_W'(pos_reg) < line_len) ? rd_data : CHAR_NUL;
    assign is_dig   = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    assign ch_off   = ch - CHAR_ZERO;
    assign dig      = ch_off[3:0];
    assign pair_val = FLD_W'(tens_reg) * 7'd10 + FLD_W'(dig);

    // one character a cycle: address for the next position goes out now
    assign rd_addr = (state_reg == CS_IDLE) ? '0 : LEN_W'(pos_reg + 4'd1);

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        fld_next   = fld_reg;
        ok_next    = ok_reg;
        tens_next  = tens_reg;
        hh_next    = hh_reg;
        mm_next    = mm_reg;
        ss_next    = ss_reg;
        case (state_reg)
            CS_IDLE: begin
                if (chk_ctl.start) begin
                    state_next = CS_PRE;
                    pos_next   = 4'd0;
                    fld_next   = 4'd0;
                    ok_next    = 1'b0;
                end
            end
            CS_PRE: begin
                pos_next = pos_reg + 4'd1;
                case (pos_reg)
                    4'd0: begin
                        if (ch != CHAR_T) begin
                            state_next = CS_DONE;
                        end
                    end
                    4'd1: begin
                        if (ch == CHAR_EQ) begin
                            state_next = CS_FIELD;
                        end else if (ch != CHAR_I) begin
                            state_next = CS_DONE;
                        end
                    end
                    4'd2: begin
                        if (ch != CHAR_M) begin
                            state_next = CS_DONE;
                        end
                    end
                    4'd3: begin
                        if (ch != CHAR_E) begin
                            state_next = CS_DONE;
                        end
                    end
                    4'd4: begin
                        state_next = (ch == CHAR_EQ) ? CS_FIELD : CS_DONE;
                    end
                    default: begin
                        state_next = CS_DONE;
                    end
                endcase
            end
            CS_FIELD: begin
                pos_next = pos_reg + 4'd1;
                fld_next = fld_reg + 4'd1;
                case (fld_reg)
                    4'd0, 4'd3, 4'd6: begin
                        tens_next = dig;
                        if (!is_dig) begin
                            state_next = CS_DONE;
                        end
                    end
                    4'd1: begin
                        hh_next = pair_val;
                        if (!is_dig) begin
                            state_next = CS_DONE;
                        end
                    end
                    4'd4: begin
                        mm_next = pair_val;
                        if (!is_dig) begin
                            state_next = CS_DONE;
                        end
                    end
                    4'd7: begin
                        ss_next = pair_val;
                        if (!is_dig) begin
                            state_next = CS_DONE;
                        end
                    end
                    4'd2, 4'd5: begin
                        if (ch != CHAR_COLON) begin
                            state_next = CS_DONE;
                        end
                    end
                    4'd8: begin
                        state_next = CS_DONE;
                        ok_next    = (ch == CHAR_NUL);
                    end
                    default: begin
                        state_next = CS_DONE;
                    end
                endcase
            end
            CS_DONE: begin
                if (chk_ctl.ack) begin
                    state_next = CS_IDLE;
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
        pos_reg  <= pos_next;
        fld_reg  <= fld_next;
        ok_reg   <= ok_next;
        tens_reg <= tens_next;
        hh_reg   <= hh_next;
        mm_reg   <= mm_next;
        ss_reg   <= ss_next;
    end

    assign chk_res.done = (state_reg == CS_DONE);
    assign chk_res.ok   = ok_reg && (hh_reg <= MAX_HOUR) && (mm_reg <= MAX_MINSEC)
                          && (ss_reg <= MAX_MINSEC);
    assign chk_res.secs = SECS_W'(hh_reg) * SECS_HOUR + SECS_W'(mm_reg) * SECS_MIN
                          + SECS_W'(ss_reg);

endmodule

// ===== rtl/serial_time_command_clock.sv =====
// channel   | handshake              | payload
// ----------+------------------------+---------------------------------------------------
// input     | s_valid / s_ready      | s_opcode, s_rx_byte
// result    | m_valid / m_ready      | m_event_res, m_seconds_of_day, m_clock_valid,
//           |                        | m_lines_received, m_times_set, m_overflows
// config    | cfg_we (no wait)       | cfg_wdata = ticks per second
//
// a tick or a plain byte has its result registered at the accepting edge
// a line end on a non-empty line walks the line store one character a cycle through the
// single ram read port, up to 14 reads, and its result is registered once the checker
// reports that it is done
// one item at a time: s_ready is low while a line is being checked or a result waits
// reset is synchronous, active low; the line store needs no clearing pass
// a stalled result holds m_valid and all fields until m_ready
module serial_time_command_clock (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [stcc_pkg::CHAR_W-1:0]   s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_event_res,
    output logic [stcc_pkg::SECS_W-1:0]   m_seconds_of_day,
    output logic                          m_clock_valid,
    output logic [stcc_pkg::CNT_W-1:0]    m_lines_received,
    output logic [stcc_pkg::CNT_W-1:0]    m_times_set,
    output logic [stcc_pkg::CNT_W-1:0]    m_overflows,
    input  logic                          cfg_we,
    input  logic [stcc_pkg::TPS_W-1:0]    cfg_wdata
);
    import stcc_pkg::*;

`include "serial_time_command_clock_assert.svh"

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_CHECK = 2'b10
    } top_state_t;

    top_state_t        state_reg, state_next;
    logic              m_valid_reg, m_valid_next;
    stcc_event_t       event_reg, event_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [SECS_W-1:0] secs_reg, secs_next;
    logic              set_reg, set_next;
    logic [TPS_W-1:0]  sub_reg, sub_next;
    logic [CNT_W-1:0]  lines_reg, lines_next;
    logic [CNT_W-1:0]  times_reg, times_next;
    logic [CNT_W-1:0]  ovf_reg, ovf_next;
    logic [TPS_W-1:0]  tps_reg;

    logic              out_free;
    logic              accept;
    logic [CHAR_W-1:0] ch_up;
    logic              is_eol;
    logic [TPS_W-1:0]  tick_limit;
    logic [TPS_W:0]    sub_inc;

    // line store port signals
    logic              wr_en;
    logic [LEN_W-1:0]  rd_addr;
    logic [CHAR_W-1:0] rd_data;

    stcc_chk_ctl_t     chk_ctl;
    stcc_chk_res_t     chk_res;

    // the result register frees as soon as the waiting item is taken
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    // upper-case fold before storing or testing for a line end
    assign ch_up  = ((s_rx_byte >= CHAR_LOW_A) && (s_rx_byte <= CHAR_LOW_Z))
                    ? (s_rx_byte - CASE_DIFF) : s_rx_byte;
    assign is_eol = (ch_up == CHAR_CR) || (ch_up == CHAR_LF);

    // a zero setting counts as one tick a second
    assign tick_limit = (tps_reg == '0) ? TPS_W'(1) : tps_reg;
    assign sub_inc    = {1'b0, sub_reg} + (TPS_W + 1)'(1);

    // bytes are written only in idle, reads only while checking: no overlap on the store
    assign wr_en = accept && (s_opcode == OP_BYTE) && !is_eol && (len_reg < LEN_LAST);

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        event_next   = event_reg;
        len_next     = len_reg;
        secs_next    = secs_reg;
        set_next     = set_reg;
        sub_next     = sub_reg;
        lines_next   = lines_reg;
        times_next   = times_reg;
        ovf_next     = ovf_reg;
        chk_ctl      = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    m_valid_next = 1'b1;
                    event_next   = EV_NONE;
                    if (s_opcode == OP_TICK) begin
                        // clock runs only once it has been set
                        if (set_reg) begin
                            if (sub_inc >= {1'b0, tick_limit}) begin
                                sub_next  = '0;
                                secs_next = (secs_reg == SEC_LAST) ? '0
                                            : secs_reg + SECS_W'(1);
                            end else begin
                                sub_next = sub_inc[TPS_W-1:0];
                            end
                        end
                    end else if (is_eol) begin
                        if (len_reg != '0) begin
                            // hand the line to the checker, result comes later
                            m_valid_next  = 1'b0;
                            chk_ctl.start = 1'b1;
                            state_next    = ST_CHECK;
                        end
                    end else if (len_reg < LEN_LAST) begin
                        len_next = len_reg + LEN_W'(1);
                    end else begin
                        // line full: drop it and count
                        len_next   = '0;
                        ovf_next   = ovf_reg + CNT_W'(1);
                        event_next = EV_OVERFLOW;
                    end
                end
            end
            ST_CHECK: begin
                if (chk_res.done && out_free) begin
                    chk_ctl.ack  = 1'b1;
                    m_valid_next = 1'b1;
                    len_next     = '0;
                    lines_next   = lines_reg + CNT_W'(1);
                    state_next   = ST_IDLE;
                    if (chk_res.ok) begin
                        secs_next  = chk_res.secs;
                        set_next   = 1'b1;
                        sub_next   = '0;
                        times_next = times_reg + CNT_W'(1);
                        event_next = EV_TIME_SET;
                    end else begin
                        event_next = EV_OTHER;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            len_reg     <= '0;
            secs_reg    <= '0;
            set_reg     <= 1'b0;
            sub_reg     <= '0;
            lines_reg   <= '0;
            times_reg   <= '0;
            ovf_reg     <= '0;
            tps_reg     <= TPS_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            len_reg     <= len_next;
            secs_reg    <= secs_next;
            set_reg     <= set_next;
            sub_reg     <= sub_next;
            lines_reg   <= lines_next;
            times_reg   <= times_next;
            ovf_reg     <= ovf_next;
            if (cfg_we) begin
                tps_reg <= cfg_wdata;
            end
        end
        event_reg <= event_next;
    end

    stcc_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (LINE_CAPACITY)
    ) u_line_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (len_reg),
        .wdata (ch_up),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    stcc_checker u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .chk_ctl  (chk_ctl),
        .line_len (len_reg),
        .rd_data  (rd_data),
        .rd_addr  (rd_addr),
        .chk_res  (chk_res)
    );

    // state changes only when a result is loaded, so the fields come straight from it
    assign m_valid          = m_valid_reg;
    assign m_event_res      = event_reg;
    assign m_seconds_of_day = secs_reg;
    assign m_clock_valid    = set_reg;
    assign m_lines_received = lines_reg;
    assign m_times_set      = times_reg;
    assign m_overflows      = ovf_reg;

    `STCC_ASSERT_IMP(a_secs_in_day, aclk, aresetn, 1'b1, secs_reg <= SEC_LAST, "bad seconds")
    `STCC_ASSERT_IMP(a_len_bound, aclk, aresetn, 1'b1, len_reg <= LEN_LAST, "line too long")
    `STCC_ASSERT_IMP(a_sub_idle, aclk, aresetn, !set_reg, sub_reg == '0, "early tick")
    `STCC_ASSERT_NXT(a_start_check, aclk, aresetn, chk_ctl.start, state_reg == ST_CHECK, "no check")
    `STCC_ASSERT_IMP(a_done_in_check, aclk, aresetn, chk_res.done, state_reg == ST_CHECK, "stray")

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import stcc_pkg::*;

    localparam int ITEMS_PER_PHASE = 315;
    localparam int PHASES          = 6;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int PRINT_LIMIT     = 40;

    // one input item: a received byte or a timer tick
    typedef struct packed {
        logic              opcode;
        logic [CHAR_W-1:0] rx_byte;
    } rx_item_t;

    // one result item as the block should report it
    typedef struct packed {
        stcc_event_t       ev;
        logic [SECS_W-1:0] secs;
        logic              valid;
        logic [CNT_W-1:0]  lines;
        logic [CNT_W-1:0]  sets;
        logic [CNT_W-1:0]  ovf;
    } clock_result_t;

    // ways a time command line is spoilt
    typedef enum int {
        FLAW_NONE,
        FLAW_RANGE,
        FLAW_COLON,
        FLAW_DIGIT,
        FLAW_TRAIL,
        FLAW_NUL_TAIL,
        FLAW_SHORT,
        FLAW_PREFIX
    } cmd_flaw_t;

    // building blocks of the random stimulus
    typedef enum int {
        SEQ_TIME,
        SEQ_BAD_TIME,
        SEQ_TICKS,
        SEQ_NOISE_LINE,
        SEQ_EMPTY_END,
        SEQ_OVERFLOW,
        SEQ_FULL_LINE,
        SEQ_STRAY
    } seq_kind_t;

    logic              aclk;
    logic              aresetn   = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    logic              s_opcode  = OP_BYTE;
    logic [CHAR_W-1:0] s_rx_byte = CHAR_NUL;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    logic [1:0]        m_event_res;
    logic [SECS_W-1:0] m_seconds_of_day;
    logic              m_clock_valid;
    logic [CNT_W-1:0]  m_lines_received;
    logic [CNT_W-1:0]  m_times_set;
    logic [CNT_W-1:0]  m_overflows;
    logic              cfg_we    = 1'b0;
    logic [TPS_W-1:0]  cfg_wdata = TPS_RESET;

    // stimulus and expectation stores
    rx_item_t          pending_items[$];
    clock_result_t     expected_results[$];
    logic [CHAR_W-1:0] cmd_text[$];

    // handshake pacing, in percent of cycles spent idle
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;

    int items_queued   = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;
    int event_tally[4] = '{default: 0};

    // predicted state of the line collector and clock
    logic [CHAR_W-1:0] line_buf[LINE_CAPACITY];
    logic [LEN_W-1:0]  line_len   = '0;
    logic [SECS_W-1:0] clk_secs   = '0;
    logic              clk_ok     = 1'b0;
    logic [TPS_W-1:0]  sub_ticks  = '0;
    logic [CNT_W-1:0]  n_lines    = '0;
    logic [CNT_W-1:0]  n_sets     = '0;
    logic [CNT_W-1:0]  n_ovf      = '0;
    logic [TPS_W-1:0]  tick_limit = TPS_RESET;

    serial_time_command_clock uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_res      (m_event_res),
        .m_seconds_of_day (m_seconds_of_day),
        .m_clock_valid    (m_clock_valid),
        .m_lines_received (m_lines_received),
        .m_times_set      (m_times_set),
        .m_overflows      (m_overflows),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // stored character, or nul at and past the line end
    function automatic logic [CHAR_W-1:0] line_char(input int pos);
        if (pos < int'(line_len)) return line_buf[pos];
        return CHAR_NUL;
    endfunction

    function automatic bit two_dec(input int pos, output int val);
        logic [CHAR_W-1:0] hi;
        logic [CHAR_W-1:0] lo;
        hi  = line_char(pos);
        lo  = line_char(pos + 1);
        val = 0;
        if (hi < CHAR_ZERO || hi > CHAR_NINE || lo < CHAR_ZERO || lo > CHAR_NINE) return 1'b0;
        val = (int'(hi) - int'(CHAR_ZERO)) * 10 + (int'(lo) - int'(CHAR_ZERO));
        return 1'b1;
    endfunction

    // decode TIME=HH:MM:SS or T=HH:MM:SS from the finished line
    function automatic bit decode_time(output logic [SECS_W-1:0] secs);
        int base;
        int hh;
        int mm;
        int ss;
        secs = '0;
        if (line_char(0) == CHAR_T && line_char(1) == CHAR_I && line_char(2) == CHAR_M &&
            line_char(3) == CHAR_E && line_char(4) == CHAR_EQ) begin
            base = 5;
        end else if (line_char(0) == CHAR_T && line_char(1) == CHAR_EQ) begin
            base = 2;
        end else begin
            return 1'b0;
        end
        // text must end right after the seconds: nul or line end
        if (!two_dec(base, hh) || line_char(base + 2) != CHAR_COLON ||
            !two_dec(base + 3, mm) || line_char(base + 5) != CHAR_COLON ||
            !two_dec(base + 6, ss) || line_char(base + 8) != CHAR_NUL) return 1'b0;
        if (hh > int'(MAX_HOUR) || mm > int'(MAX_MINSEC) || ss > int'(MAX_MINSEC)) return 1'b0;
        secs = SECS_W'(hh * int'(SECS_HOUR) + mm * int'(SECS_MIN) + ss);
        return 1'b1;
    endfunction

    // apply one accepted item to the predicted state, return its result
    function automatic clock_result_t advance_clock(input logic op, input logic [CHAR_W-1:0] rx);
        clock_result_t     r;
        logic [CHAR_W-1:0] ch;
        logic [SECS_W-1:0] secs;
        int                ticks_next;
        r.ev = EV_NONE;
        if (op == OP_TICK) begin
            // ticks only count once the clock has been set
            if (clk_ok) begin
                ticks_next = int'(sub_ticks) + 1;
                if (tick_limit == '0 || ticks_next >= int'(tick_limit)) begin
                    sub_ticks = '0;
                    clk_secs  = (clk_secs == SEC_LAST) ? '0 : clk_secs + 1'b1;
                end else begin
                    sub_ticks = TPS_W'(ticks_next);
                end
            end
        end else begin
            ch = rx;
            if (ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z) ch = ch - CASE_DIFF;
            if (ch == CHAR_CR || ch == CHAR_LF) begin
                // an empty line end is silent
                if (line_len != '0) begin
                    n_lines++;
                    if (decode_time(secs)) begin
                        clk_secs  = secs;
                        clk_ok    = 1'b1;
                        sub_ticks = '0;
                        n_sets++;
                        r.ev = EV_TIME_SET;
                    end else begin
                        r.ev = EV_OTHER;
                    end
                end
                line_len = '0;
            end else if (line_len < LEN_LAST) begin
                line_buf[line_len] = ch;
                line_len++;
            end else begin
                // line full: drop it and count
                line_len = '0;
                n_ovf++;
                r.ev = EV_OVERFLOW;
            end
        end
        r.secs  = clk_secs;
        r.valid = clk_ok;
        r.lines = n_lines;
        r.sets  = n_sets;
        r.ovf   = n_ovf;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // driver: presents queued items, predicts each one as it is accepted
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(advance_clock(s_opcode, s_rx_byte));
                items_accepted++;
            end
            // payload may only move once the current item has gone
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_opcode  <= pending_items[0].opcode;
                    s_rx_byte <= pending_items[0].rx_byte;
                    void'(pending_items.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each result item against the oldest expectation
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_LIMIT) $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    always @(posedge aclk) begin : result_monitor
        clock_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d with nothing expected", results_seen));
                end else begin
                    want = expected_results.pop_front();
                    if (m_event_res !== want.ev)
                        report_mismatch($sformatf("result %0d event %0d, want %0d",
                            results_seen, m_event_res, want.ev));
                    if (m_seconds_of_day !== want.secs)
                        report_mismatch($sformatf("result %0d seconds %0d, want %0d",
                            results_seen, m_seconds_of_day, want.secs));
                    if (m_clock_valid !== want.valid)
                        report_mismatch($sformatf("result %0d clock valid %b, want %b",
                            results_seen, m_clock_valid, want.valid));
                    if (m_lines_received !== want.lines)
                        report_mismatch($sformatf("result %0d lines %0d, want %0d",
                            results_seen, m_lines_received, want.lines));
                    if (m_times_set !== want.sets)
                        report_mismatch($sformatf("result %0d time sets %0d, want %0d",
                            results_seen, m_times_set, want.sets));
                    if (m_overflows !== want.ovf)
                        report_mismatch($sformatf("result %0d overflows %0d, want %0d",
                            results_seen, m_overflows, want.ovf));
                end
                if (!$isunknown(m_event_res)) event_tally[m_event_res]++;
                results_seen++;
            end
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // watchdog: cycles without any handshake on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("[serial_time_command_clock] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(input logic op, input logic [CHAR_W-1:0] b);
        pending_items.push_back('{opcode: op, rx_byte: b});
        items_queued++;
    endtask

    // any byte that does not end a line
    function automatic logic [CHAR_W-1:0] fill_byte();
        logic [CHAR_W-1:0] b;
        do b = CHAR_W'($urandom_range(255)); while (b == CHAR_CR || b == CHAR_LF);
        return b;
    endfunction

    function automatic logic [CHAR_W-1:0] line_end();
        return $urandom_range(1) ? CHAR_CR : CHAR_LF;
    endfunction

    // push the scratch text, letters optionally in mixed case
    task automatic push_text(input bit mixed_case);
        logic [CHAR_W-1:0] b;
        foreach (cmd_text[i]) begin
            b = cmd_text[i];
            if (mixed_case && b >= CHAR_LOW_A - CASE_DIFF && b <= CHAR_LOW_Z - CASE_DIFF &&
                $urandom_range(1)) b = b | CASE_DIFF;
            push_item(OP_BYTE, b);
        end
    endtask

    task automatic compose_time(input int hh, input int mm, input int ss, input bit long_form);
        cmd_text.delete();
        cmd_text.push_back(CHAR_T);
        if (long_form) begin
            cmd_text.push_back(CHAR_I);
            cmd_text.push_back(CHAR_M);
            cmd_text.push_back(CHAR_E);
        end
        cmd_text.push_back(CHAR_EQ);
        cmd_text.push_back(CHAR_ZERO + CHAR_W'(hh / 10));
        cmd_text.push_back(CHAR_ZERO + CHAR_W'(hh % 10));
        cmd_text.push_back(CHAR_COLON);
        cmd_text.push_back(CHAR_ZERO + CHAR_W'(mm / 10));
        cmd_text.push_back(CHAR_ZERO + CHAR_W'(mm % 10));
        cmd_text.push_back(CHAR_COLON);
        cmd_text.push_back(CHAR_ZERO + CHAR_W'(ss / 10));
        cmd_text.push_back(CHAR_ZERO + CHAR_W'(ss % 10));
    endtask

    // a time command line, well formed or spoilt in one way
    task automatic push_time_line(input cmd_flaw_t flaw);
        int hh;
        int mm;
        int ss;
        int base;
        bit long_form;
        hh = $urandom_range(MAX_HOUR);
        mm = $urandom_range(MAX_MINSEC);
        ss = $urandom_range(MAX_MINSEC);
        // day boundaries now and then
        case ($urandom_range(7))
            0: begin hh = MAX_HOUR; mm = MAX_MINSEC; ss = MAX_MINSEC; end
            1: begin hh = 0; mm = 0; ss = 0; end
            default: ;
        endcase
        if (flaw == FLAW_RANGE) begin
            case ($urandom_range(2))
                0: hh = $urandom_range(99, MAX_HOUR + 1);
                1: mm = $urandom_range(99, MAX_MINSEC + 1);
                default: ss = $urandom_range(99, MAX_MINSEC + 1);
            endcase
        end
        long_form = $urandom_range(1);
        base      = long_form ? 5 : 2;
        compose_time(hh, mm, ss, long_form);
        case (flaw)
            FLAW_COLON: begin
                cmd_text[base + ($urandom_range(1) ? 2 : 5)] = CHAR_COLON ^ CHAR_W'($urandom_range(255, 1));
            end
            FLAW_DIGIT: begin
                // just outside the digit range on either side
                cmd_text[base + 3 * $urandom_range(2) + $urandom_range(1)] =
                    $urandom_range(1) ? CHAR_ZERO - 1'b1 : CHAR_NINE + 1'b1;
            end
            FLAW_TRAIL:    cmd_text.push_back(fill_byte() | 8'h01);
            FLAW_NUL_TAIL: begin
                // text ends at the nul, so junk after it is harmless
                cmd_text.push_back(CHAR_NUL);
                repeat ($urandom_range(3)) cmd_text.push_back(fill_byte());
            end
            FLAW_SHORT:    repeat ($urandom_range(3, 1)) void'(cmd_text.pop_back());
            FLAW_PREFIX:   cmd_text[base - 1] = CHAR_EQ ^ CHAR_W'($urandom_range(255, 1));
            default: ;
        endcase
        // close any half-built line first, sometimes
        if ($urandom_range(1)) push_item(OP_BYTE, line_end());
        push_text(1'b1);
        push_item(OP_BYTE, line_end());
    endtask

    // a line end, then the longest line the store takes, then one more byte or a line end
    task automatic push_long_line(input bit overflow);
        push_item(OP_BYTE, CHAR_LF);
        repeat (int'(LEN_LAST)) push_item(OP_BYTE, fill_byte());
        if (overflow) begin
            push_item(OP_BYTE, fill_byte());
            if ($urandom_range(1)) push_item(OP_BYTE, line_end());
        end else begin
            push_item(OP_BYTE, line_end());
        end
    endtask

    function automatic seq_kind_t pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 30) return SEQ_TIME;
        if (r < 50) return SEQ_BAD_TIME;
        if (r < 66) return SEQ_TICKS;
        if (r < 76) return SEQ_NOISE_LINE;
        if (r < 82) return SEQ_EMPTY_END;
        if (r < 84) return SEQ_OVERFLOW;
        if (r < 85) return SEQ_FULL_LINE;
        return SEQ_STRAY;
    endfunction

    task automatic fill_phase(input int ph, input int target);
        int        start;
        seq_kind_t kind;
        start = items_queued;
        while (items_queued - start < target) begin
            kind = pick_kind();
            // make sure the long-line cases turn up
            if (items_queued == start && ph == 1) kind = SEQ_OVERFLOW;
            if (items_queued == start && ph == 4) kind = SEQ_FULL_LINE;
            case (kind)
                SEQ_TIME:     push_time_line(FLAW_NONE);
                SEQ_BAD_TIME: push_time_line(cmd_flaw_t'($urandom_range(FLAW_PREFIX, FLAW_RANGE)));
                SEQ_TICKS:    repeat ($urandom_range(12, 1))
                                  push_item(OP_TICK, CHAR_W'($urandom_range(255)));
                SEQ_NOISE_LINE: begin
                    repeat ($urandom_range(12, 1)) push_item(OP_BYTE, CHAR_W'($urandom_range(255)));
                    push_item(OP_BYTE, line_end());
                end
                SEQ_EMPTY_END: repeat ($urandom_range(2, 1)) push_item(OP_BYTE, line_end());
                SEQ_OVERFLOW:  push_long_line(1'b1);
                SEQ_FULL_LINE: push_long_line(1'b0);
                default:       repeat ($urandom_range(3, 1))
                                   push_item(logic'($urandom_range(1)), CHAR_W'($urandom_range(255)));
            endcase
        end
    endtask

    // wait until no item is queued, in flight or owed a result
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0);
    endtask

    // only called with the block idle
    task automatic write_tps(input logic [TPS_W-1:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        tick_limit = v;
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [TPS_W-1:0] tps;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            // pacing: slow receiver, then slow sender, then full speed
            if (ph < 2) begin
                sender_idle_pct   = 38;
                receiver_idle_pct = 88;
            end else if (ph < 4) begin
                sender_idle_pct   = 88;
                receiver_idle_pct = 38;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            // tick rate: one, the maximum, lowered below the running count, the reset value, random, five
            case (ph)
                0: tps = 16'd1;
                1: tps = 16'hFFFF;
                2: tps = 16'd2;
                3: tps = TPS_RESET;
                4: tps = TPS_W'($urandom_range(40, 3));
                default: tps = 16'd5;
            endcase
            write_tps(tps);

            if (ph == 0) begin
                push_item(OP_TICK, CHAR_NUL);       // tick before the clock is set
                push_item(OP_BYTE, CHAR_CR);        // empty line end
                compose_time(MAX_HOUR, MAX_MINSEC, MAX_MINSEC, 1'b0);
                cmd_text[0] = CHAR_T | CASE_DIFF;   // lower-case command letter
                push_text(1'b0);
                push_item(OP_BYTE, CHAR_LF);
                push_item(OP_TICK, CHAR_NUL);       // one tick a second: wraps to midnight
                push_item(OP_TICK, 8'hFF);
                // byte extremes and the edges of case folding, then a plain line end
                push_item(OP_BYTE, 8'hFF);
                push_item(OP_BYTE, CHAR_NUL);
                push_item(OP_BYTE, CHAR_LOW_A - 1'b1);
                push_item(OP_BYTE, CHAR_LOW_A);
                push_item(OP_BYTE, CHAR_LOW_Z);
                push_item(OP_BYTE, CHAR_LOW_Z + 1'b1);
                push_item(OP_BYTE, CHAR_CR);
            end
            fill_phase(ph, ITEMS_PER_PHASE);
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        $display("covered %0d items in %0d tick-rate settings and three pacing modes",
            items_accepted, PHASES);
        $display("results: %0d time sets, %0d other lines, %0d overflows, %0d mismatches",
            event_tally[EV_TIME_SET], event_tally[EV_OTHER], event_tally[EV_OVERFLOW], mismatches);
        if (mismatches == 0) begin
            $display("[serial_time_command_clock] OK");
        end else begin
            $display("[serial_time_command_clock] ERROR");
        end
        $finish;
    end

endmodule
